// ===== hw/rtl/rv32i_pkg.sv =====
// shared types and constants for the rv32i step core
package rv32i_pkg;

   localparam int MemBytes = 65536;
   localparam int AddrW = $clog2(MemBytes);
   localparam int RowW = AddrW - 2;

   localparam logic [31:0] HaltWord = 32'h0FF0_0513;

   localparam logic [6:0] OpLui    = 7'h37;
   localparam logic [6:0] OpAuipc  = 7'h17;
   localparam logic [6:0] OpJal    = 7'h6F;
   localparam logic [6:0] OpJalr   = 7'h67;
   localparam logic [6:0] OpBranch = 7'h63;
   localparam logic [6:0] OpLoad   = 7'h03;
   localparam logic [6:0] OpStore  = 7'h23;
   localparam logic [6:0] OpImm    = 7'h13;
   localparam logic [6:0] OpReg    = 7'h33;
   localparam logic [6:0] F7Alt    = 7'h20;

   localparam logic ReqLoad = 1'b0;
   localparam logic ReqStep = 1'b1;

   typedef struct packed {
      logic start_load;  // write load word, capture result
      logic start_fetch; // read instruction row
      logic decode;      // instruction rows ready, fill instruction register
      logic execute;     // do alu, store, writeback
      logic out_take;    // result taken
   } rv32i_cmd_type;

   typedef struct packed {
      logic out_valid;
   } rv32i_sts_type;

endpackage

// ===== hw/rtl/rv32i_instruction_step.sv =====
// rv32i step core: load items fill memory, step items run one instruction each
// A load item writes memory and its result from idle. A step item goes from acceptance to the
// result register through instruction row read, instruction register, operand latch with the
// data row read, the remaining controller states, then execute and writeback, which waits
// while a result is held at the output and not taken; the next item is taken back in idle. The
// timing is set by the single registered read port of the memory, used once for the instruction
// and once for load data. A result waiting at the output holds off the next item.
module rv32i_instruction_step
   import rv32i_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // load_address[15:0], load_word[47:16]
   input  logic        req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata   // executed_pc, next_pc, dest_register, dest_value,
                                   // halted, answer_byte, from bit 0 up
);

   rv32i_cmd_type cmd;
   rv32i_sts_type sts;

   rv32i_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_op(req_tuser),
      .rsp_tready, .sts, .cmd
   );

   rv32i_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .load_address(req_tdata[15:0]), .load_word(req_tdata[47:16]),
      .rsp_data(rsp_tdata)
   );

   assign rsp_tvalid = sts.out_valid;

endmodule

// ===== hw/rtl/rv32i_datapath.sv =====
// register file, memory, pc and execute logic of the rv32i step core
module rv32i_datapath
   import rv32i_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  rv32i_cmd_type cmd,
   output rv32i_sts_type sts,
   input  logic [15:0]   load_address,
   input  logic [31:0]   load_word,
   output logic [79:0]   rsp_data
);

   // memory as two banks of 32-bit rows: row r and row r+1 cover any word
   logic [31:0] mem_even [MemBytes/8];
   logic [31:0] mem_odd  [MemBytes/8];
   logic [31:0] regs_ff [32];
   logic [AddrW-1:0] pc_ff;
   logic halt_ff;
   logic [31:0] ev_rd_ff, od_rd_ff;
   logic [31:0] ins_ff;
   logic [AddrW-1:0] ins_adr_ff;
   logic [31:0] a_ff, b_ff;
   logic [AddrW-1:0] dadr_ff;
   logic out_valid_ff;
   logic [15:0] r_epc_ff, r_npc_ff;
   logic [4:0] r_rd_ff;
   logic [31:0] r_val_ff;
   logic r_halt_ff;
   logic [7:0] r_ans_ff;
   logic [AddrW-1:0] dadr;

   // read address for the two row banks (row of low byte and next)
   logic [AddrW-1:0] radr;
   logic [RowW-1:0] row0, row1;
   logic [RowW-2:0] ev_row, od_row;
   always_comb begin
      radr = cmd.start_fetch ? pc_ff : dadr;
      row0 = radr[AddrW-1:2];
      row1 = row0 + RowW'(1);
      ev_row = row0[0] ? row1[RowW-1:1] : row0[RowW-1:1];
      od_row = row0[0] ? row0[RowW-1:1] : row1[RowW-1:1];
   end

   // 64-bit window starting at row of given address, shifted to byte
   function automatic logic [31:0] win(input logic [31:0] ev, input logic [31:0] od,
                                       input logic [AddrW-1:0] adr);
      logic [63:0] w;
      begin
         w = adr[2] ? {ev, od} : {od, ev};
         w = w >> {adr[1:0], 3'b000};
         win = w[31:0];
      end
   endfunction

   logic [31:0] code;
   assign code = ins_ff;
   logic [6:0] op;
   logic [4:0] rd;
   logic [2:0] f3;
   logic [6:0] f7;
   logic [31:0] immi, imms, immb, immu, immj;
   always_comb begin
      op = code[6:0]; rd = code[11:7]; f3 = code[14:12]; f7 = code[31:25];
      immi = {{20{code[31]}}, code[31:20]};
      imms = {{20{code[31]}}, code[31:25], code[11:7]};
      immb = {{19{code[31]}}, code[31], code[7], code[30:25], code[11:8], 1'b0};
      immu = {code[31:12], 12'd0};
      immj = {{11{code[31]}}, code[31], code[19:12], code[20], code[30:21], 1'b0};
   end

   // data address in decode, from register read
   logic [31:0] rs1v, dsum;
   always_comb begin
      rs1v = regs_ff[code[19:15]];
      dsum = rs1v + ((op == OpStore) ? imms : immi);
      dadr = dsum[AddrW-1:0];
   end

   // execute
   logic [31:0] a, b, ld, res, pcx, nxt, bo;
   logic wr, st, lts, ltu;
   logic [4:0] sh;
   logic [3:0] be;
   logic [31:0] sdat;
   always_comb begin
      a = a_ff; b = b_ff;
      pcx = {{(32-AddrW){1'b0}}, ins_adr_ff};
      ld = win(ev_rd_ff, od_rd_ff, dadr_ff);
      nxt = pcx + 32'd4;
      wr = 1'b0; res = '0; st = 1'b0; be = 4'b0000;
      bo = (op == OpImm) ? immi : b;
      sh = (op == OpImm) ? code[24:20] : b[4:0];
      lts = $signed(a) < $signed(bo);
      ltu = a < bo;
      unique case (op) inside
         OpLui:   begin wr = 1'b1; res = immu; end
         OpAuipc: begin wr = 1'b1; res = pcx + immu; end
         OpJal:   begin wr = 1'b1; res = nxt; nxt = pcx + immj; end
         OpJalr:  begin wr = 1'b1; res = nxt; nxt = (a + immi) & ~32'd1; end
         OpBranch: begin
            case (f3)
               3'd0: if (a == b) nxt = pcx + immb;
               3'd1: if (a != b) nxt = pcx + immb;
               3'd4: if (lts) nxt = pcx + immb;
               3'd5: if (!lts) nxt = pcx + immb;
               3'd6: if (ltu) nxt = pcx + immb;
               3'd7: if (!ltu) nxt = pcx + immb;
               default: ;
            endcase
         end
         OpLoad: begin
            wr = 1'b1;
            case (f3)
               3'd0: res = {{24{ld[7]}}, ld[7:0]};
               3'd1: res = {{16{ld[15]}}, ld[15:0]};
               3'd2: res = ld;
               3'd4: res = {24'd0, ld[7:0]};
               3'd5: res = {16'd0, ld[15:0]};
               default: wr = 1'b0;
            endcase
         end
         OpStore: begin
            st = 1'b1;
            case (f3)
               3'd0: be = 4'b0001;
               3'd1: be = 4'b0011;
               3'd2: be = 4'b1111;
               default: st = 1'b0;
            endcase
         end
         OpImm, OpReg: begin
            wr = 1'b1;
            if (op == OpReg && f7 == F7Alt && f3 == 3'd0) res = a - b;
            else if (f3 == 3'd5 && f7 == F7Alt) res = $unsigned($signed(a) >>> sh);
            else if (f7 != 7'd0 && (op == OpReg || f3 == 3'd1 || f3 == 3'd5)) wr = 1'b0;
            else begin
               case (f3)
                  3'd0: res = a + bo;
                  3'd1: res = a << sh;
                  3'd2: res = {31'd0, lts};
                  3'd3: res = {31'd0, ltu};
                  3'd4: res = a ^ bo;
                  3'd5: res = a >> sh;
                  3'd6: res = a | bo;
                  default: res = a & bo;
               endcase
            end
         end
         default: ;
      endcase
      sdat = b;
   end

   // write port: one address, byte enables over an 8-byte window
   logic [AddrW-1:0] wadr;
   logic [31:0] wdat;
   logic [3:0] wbe;
   logic wen;
   logic [63:0] wwin;
   logic [7:0] wmask;
   logic [RowW-1:0] wrow0, wrow1;
   logic [RowW-2:0] ev_wrow, od_wrow;
   logic [31:0] ev_wd, od_wd;
   logic [3:0] ev_be, od_be;
   always_comb begin
      wen = cmd.start_load || (cmd.execute && !halt_ff && ins_ff != HaltWord && st);
      wadr = cmd.start_load ? AddrW'(load_address) : dadr_ff;
      wdat = cmd.start_load ? load_word : sdat;
      wbe = cmd.start_load ? 4'b1111 : be;
      wwin = {32'd0, wdat} << {wadr[1:0], 3'b000};
      wmask = {4'd0, wbe} << wadr[1:0];
      wrow0 = wadr[AddrW-1:2];
      wrow1 = wrow0 + RowW'(1);
      if (wrow0[0]) begin
         ev_wrow = wrow1[RowW-1:1]; od_wrow = wrow0[RowW-1:1];
         od_wd = wwin[31:0]; od_be = wmask[3:0];
         ev_wd = wwin[63:32]; ev_be = wmask[7:4];
      end else begin
         ev_wrow = wrow0[RowW-1:1]; od_wrow = wrow1[RowW-1:1];
         ev_wd = wwin[31:0]; ev_be = wmask[3:0];
         od_wd = wwin[63:32]; od_be = wmask[7:4];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (wen && ev_be[i]) mem_even[ev_wrow][i*8 +: 8] <= ev_wd[i*8 +: 8];
         if (wen && od_be[i]) mem_odd[od_wrow][i*8 +: 8] <= od_wd[i*8 +: 8];
      end
      ev_rd_ff <= mem_even[ev_row];
      od_rd_ff <= mem_odd[od_row];
   end

   logic do_exec;
   assign do_exec = cmd.execute && !halt_ff && ins_ff != HaltWord;

   logic wb_en;
   assign wb_en = do_exec && wr && rd != 5'd0;

   always_ff @(posedge clock) begin
      if (cmd.start_fetch) ins_adr_ff <= pc_ff;
      if (cmd.decode) begin
         ins_ff <= win(ev_rd_ff, od_rd_ff, ins_adr_ff);
      end
   end

   // operands latched in the cycle after the instruction register fills
   logic dec2_ff;
   always_ff @(posedge clock) begin
      if (reset) dec2_ff <= 1'b0;
      else dec2_ff <= cmd.decode;
      if (dec2_ff) begin
         a_ff <= rs1v;
         b_ff <= regs_ff[code[24:20]];
         dadr_ff <= dadr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) regs_ff[i] <= '0;
         pc_ff <= '0;
         halt_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= (out_valid_ff && !cmd.out_take) || cmd.start_load || cmd.execute;
         if (cmd.start_load) begin
            r_epc_ff <= '0; r_npc_ff <= 16'(pc_ff);
            r_rd_ff <= '0; r_val_ff <= '0;
            r_halt_ff <= halt_ff;
            r_ans_ff <= halt_ff ? regs_ff[10][7:0] : 8'd0;
         end
         if (cmd.execute) begin
            r_epc_ff <= 16'(ins_adr_ff);
            r_rd_ff <= wb_en ? rd : 5'd0;
            r_val_ff <= wb_en ? res : 32'd0;
            if (halt_ff || ins_ff == HaltWord) begin
               halt_ff <= 1'b1;
               r_npc_ff <= 16'(pc_ff);
               r_halt_ff <= 1'b1;
               r_ans_ff <= regs_ff[10][7:0];
            end else begin
               pc_ff <= nxt[AddrW-1:0];
               r_npc_ff <= 16'(nxt[AddrW-1:0]);
               r_halt_ff <= 1'b0;
               r_ans_ff <= '0;
               if (wb_en) regs_ff[rd] <= res;
            end
         end
      end
   end

   assign sts.out_valid = out_valid_ff;
   assign rsp_data = {2'b00, r_ans_ff, r_halt_ff, r_val_ff, r_rd_ff, r_npc_ff, r_epc_ff};

endmodule

// ===== hw/rtl/rv32i_ctrl.sv =====
// sequencing state machine of the rv32i step core
module rv32i_ctrl
   import rv32i_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_op,
   input  logic          rsp_tready,
   input  rv32i_sts_type sts,
   output rv32i_cmd_type cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_FETCH  = 6'b000010,
      S_DECODE = 6'b000100,
      S_OPER   = 6'b001000,
      S_DATA   = 6'b010000,
      S_EXEC   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic acc;

   // a new item is taken in idle once the output register is free or being emptied
   assign req_tready = (state_ff == S_IDLE) && (!sts.out_valid || rsp_tready);
   assign acc = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.out_take = sts.out_valid && rsp_tready;
      unique case (state_ff)
         S_IDLE: if (acc) begin
            if (req_op == ReqLoad) cmd.start_load = 1'b1;
            else begin cmd.start_fetch = 1'b1; state_in = S_FETCH; end
         end
         // instruction rows were registered on acceptance; the instruction register fills here
         S_FETCH:  begin cmd.decode = 1'b1; state_in = S_DECODE; end
         S_DECODE: state_in = S_OPER;
         S_OPER:   state_in = S_DATA;
         S_DATA:   state_in = S_EXEC;
         S_EXEC: if (!sts.out_valid || rsp_tready) begin
            cmd.execute = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   ap_exec_room: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (!sts.out_valid || rsp_tready)) else $error("result overwritten");
   ap_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready while busy");
   ap_step_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.start_fetch |=> state_ff == S_FETCH) else $error("fetch lost");

endmodule

// ===== tb/tb.sv =====
// self-checking stream testbench for the rv32i step core
module tb;
   import rv32i_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        kind;
      logic [15:0] addr;
      logic [31:0] word;
      logic        drain;
   } req_item_t;

   typedef struct packed {
      logic [7:0]  answer_byte;
      logic        halted;
      logic [31:0] dest_value;
      logic [4:0]  dest_register;
      logic [15:0] next_pc;
      logic [15:0] executed_pc;
   } step_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;

   rv32i_instruction_step DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // core model state
   logic [31:0]  core_regs [0:31];
   logic [15:0]  core_pc;
   logic         core_halted;
   logic [7:0]   core_mem [0:65535];
   bit           mem_written [0:65535];

   req_item_t    pending_items[$];
   step_result_t expected_results[$];
   int           n_sent, n_done, n_errors, n_loads, n_steps;
   int           gap_left, hold_left;
   bit           calm, long_hold_done;

   function automatic logic [31:0] mem_rd(input logic [31:0] a, input int n);
      logic [31:0] v;
      v = '0;
      for (int i = 0; i < n; i++) v |= 32'(core_mem[16'(a + i)]) << (8 * i);
      return v;
   endfunction

   function automatic bit mem_known(input logic [31:0] a, input int n);
      for (int i = 0; i < n; i++) if (!mem_written[16'(a + i)]) return 0;
      return 1;
   endfunction

   task automatic mem_wr(input logic [31:0] a, input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++) begin
         core_mem[16'(a + i)] = v[8*i +: 8];
         mem_written[16'(a + i)] = 1;
      end
   endtask

   // bytes read by a load instruction, 0 if none
   function automatic int load_bytes(input logic [2:0] f3);
      case (f3) inside
         3'd0, 3'd4: return 1;
         3'd1, 3'd5: return 2;
         3'd2: return 4;
         default: return 0;
      endcase
   endfunction

   task automatic run_core(input req_item_t it, output step_result_t r);
      logic [31:0] c, a, b, immi, imms, immb, immj, nxt, res, pc32, ad, ld;
      logic [4:0]  rd, sh;
      logic [2:0]  f3;
      logic [6:0]  f7;
      bit          wr, take, known;
      r = '0;
      if (it.kind == ReqLoad) begin
         mem_wr(it.addr, it.word, 4);
      end else if (core_halted) begin
         r.executed_pc = core_pc;
      end else begin
         pc32 = {16'd0, core_pc};
         c = mem_rd(pc32, 4);
         r.executed_pc = core_pc;
         if (c == HaltWord) begin
            core_halted = 1;
         end else begin
            rd = c[11:7]; f3 = c[14:12]; f7 = c[31:25]; sh = c[24:20];
            a = core_regs[c[19:15]];
            b = core_regs[c[24:20]];
            immi = {{20{c[31]}}, c[31:20]};
            imms = {{20{c[31]}}, c[31:25], c[11:7]};
            immb = {{19{c[31]}}, c[31], c[7], c[30:25], c[11:8], 1'b0};
            immj = {{11{c[31]}}, c[31], c[19:12], c[20], c[30:21], 1'b0};
            nxt = pc32 + 4;
            wr = 0;
            res = '0;
            case (c[6:0])
               OpLui: begin wr = 1; res = {c[31:12], 12'd0}; end
               OpAuipc: begin wr = 1; res = pc32 + {c[31:12], 12'd0}; end
               OpJal: begin wr = 1; res = pc32 + 4; nxt = pc32 + immj; end
               OpJalr: begin wr = 1; res = pc32 + 4; nxt = (a + immi) & ~32'd1; end
               OpBranch: begin
                  known = 1;
                  take = 0;
                  case (f3)
                     3'd0: take = a == b;
                     3'd1: take = a != b;
                     3'd4: take = $signed(a) < $signed(b);
                     3'd5: take = $signed(a) >= $signed(b);
                     3'd6: take = a < b;
                     3'd7: take = a >= b;
                     default: known = 0;
                  endcase
                  if (known && take) nxt = pc32 + immb;
               end
               OpLoad: begin
                  ad = a + immi;
                  ld = mem_rd(ad, 4);
                  wr = 1;
                  case (f3)
                     3'd0: res = {{24{ld[7]}}, ld[7:0]};
                     3'd1: res = {{16{ld[15]}}, ld[15:0]};
                     3'd2: res = ld;
                     3'd4: res = {24'd0, ld[7:0]};
                     3'd5: res = {16'd0, ld[15:0]};
                     default: wr = 0;
                  endcase
               end
               OpStore: begin
                  ad = a + imms;
                  if (f3 <= 3'd2) mem_wr(ad, b, 1 << f3);
               end
               OpImm: begin
                  wr = 1;
                  case (f3)
                     3'd0: res = a + immi;
                     3'd2: res = {31'd0, $signed(a) < $signed(immi)};
                     3'd3: res = {31'd0, a < immi};
                     3'd4: res = a ^ immi;
                     3'd6: res = a | immi;
                     3'd7: res = a & immi;
                     3'd1: if (f7 == 7'd0) res = a << sh; else wr = 0;
                     default: begin
                        if (f7 == 7'd0) res = a >> sh;
                        else if (f7 == F7Alt) res = $signed(a) >>> sh;
                        else wr = 0;
                     end
                  endcase
               end
               OpReg: begin
                  wr = 1;
                  if (f7 == F7Alt && f3 == 3'd0) res = a - b;
                  else if (f7 == F7Alt && f3 == 3'd5) res = $signed(a) >>> b[4:0];
                  else if (f7 != 7'd0) wr = 0;
                  else begin
                     case (f3)
                        3'd0: res = a + b;
                        3'd1: res = a << b[4:0];
                        3'd2: res = {31'd0, $signed(a) < $signed(b)};
                        3'd3: res = {31'd0, a < b};
                        3'd4: res = a ^ b;
                        3'd5: res = a >> b[4:0];
                        3'd6: res = a | b;
                        default: res = a & b;
                     endcase
                  end
               end
               default: ;
            endcase
            if (wr && rd != 5'd0) begin
               core_regs[rd] = res;
               r.dest_register = rd;
               r.dest_value = res;
            end
            core_pc = nxt[15:0];
         end
      end
      r.next_pc = core_pc;
      r.halted = core_halted;
      r.answer_byte = core_halted ? core_regs[10][7:0] : 8'd0;
   endtask

   task automatic queue_item(input logic kind, input logic [15:0] addr,
                             input logic [31:0] word, input bit drain);
      req_item_t    it;
      step_result_t r;
      it = '{kind: kind, addr: addr, word: word, drain: drain};
      run_core(it, r);
      pending_items.push_back(it);
      expected_results.push_back(r);
      if (kind == ReqLoad) n_loads++; else n_steps++;
   endtask

   function automatic logic [31:0] rand_instr();
      logic [6:0]  ops [9] = '{OpLui, OpAuipc, OpJal, OpJalr, OpBranch, OpLoad,
                               OpStore, OpImm, OpReg};
      logic [31:0] c;
      int          k;
      c = $urandom();
      k = $urandom_range(0, 12);
      if (k < 9) c[6:0] = ops[k];
      else if (k < 11) c[6:0] = $urandom_range(0, 1) ? OpImm : OpReg;
      if ((c[6:0] == OpImm && (c[14:12] == 3'd1 || c[14:12] == 3'd5) ||
           c[6:0] == OpReg) && $urandom_range(0, 3) != 0)
         c[31:25] = $urandom_range(0, 1) ? F7Alt : 7'd0;
      if (c == HaltWord) c = 32'h0000_0013;
      return c;
   endfunction

   // step only when the fetch and any load data touch written bytes
   task automatic queue_step(input bit allow_halt, input bit drain);
      logic [31:0] w, ad;
      bit          ok;
      for (int k = 0; k < 5; k++) begin
         ok = 1;
         if (!core_halted) begin
            if (!mem_known(core_pc, 4) || (!allow_halt && mem_rd(core_pc, 4) == HaltWord)) begin
               ok = 0;
               if (k < 4) queue_item(ReqLoad, core_pc, rand_instr(), 0);
               else queue_item(ReqLoad, core_pc, 32'h0000_0013, 0);
            end else begin
               w = mem_rd(core_pc, 4);
               ad = core_regs[w[19:15]] + {{20{w[31]}}, w[31:20]};
               if (w[6:0] == OpLoad && !mem_known(ad, load_bytes(w[14:12]))) begin
                  ok = 0;
                  if (k < 4) queue_item(ReqLoad, ad[15:0], $urandom(), 0);
                  else queue_item(ReqLoad, core_pc, 32'h0000_0013, 0);
               end
            end
         end
         if (ok) break;
      end
      queue_item(ReqStep, 16'($urandom()), $urandom(), drain);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) n_sent++;
         calm = pending_items.size() < 40;
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].drain && n_done != n_sent)) begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_items[0].kind;
               req_tdata <= {pending_items[0].word, pending_items[0].addr};
               void'(pending_items.pop_front());
               if (!calm && $urandom_range(0, 6) == 0) gap_left = $urandom_range(1, 11);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      step_result_t got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[77:0];
            n_done++;
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing expected, actual %h", $time, got);
               n_errors++;
            end else begin
               want = expected_results.pop_front();
               if (got.executed_pc !== want.executed_pc ||
                   got.next_pc !== want.next_pc ||
                   got.dest_register !== want.dest_register ||
                   got.dest_value !== want.dest_value ||
                   got.halted !== want.halted ||
                   got.answer_byte !== want.answer_byte) begin
                  $display("%0t: mismatch expected pc %h next %h rd %0d val %h halt %b ans %h",
                           $time, want.executed_pc, want.next_pc, want.dest_register,
                           want.dest_value, want.halted, want.answer_byte);
                  $display("%0t:          actual   pc %h next %h rd %0d val %h halt %b ans %h",
                           $time, got.executed_pc, got.next_pc, got.dest_register,
                           got.dest_value, got.halted, got.answer_byte);
                  n_errors++;
               end
            end
         end
         // long hold-off so the core backs up and stalls its input
         if (!long_hold_done && n_sent >= 150) begin
            long_hold_done = 1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      logic [31:0] prog [12] = '{
         32'hFFF0_0093, 32'h8000_0137, 32'h0020_F1B3, 32'h41F1_5213,
         32'h01F0_9293, 32'hFE10_2E23, 32'hFFE0_2303, 32'h0010_0013,
         32'h0000_000F, 32'hFFFF_FFFF, 32'h4020_8433, 32'h0010_03E7};
      for (int i = 0; i < 32; i++) core_regs[i] = '0;
      core_pc = '0;
      core_halted = 0;
      // directed: extremes, wrap, misaligned, x0 write, no-ops, jalr bit clear
      for (int i = 0; i < 12; i++) queue_item(ReqLoad, 16'(4 * i), prog[i], 0);
      queue_item(ReqLoad, 16'hFFFF, 32'hFFFF_FFFF, 0);
      queue_item(ReqLoad, 16'h8000, 32'h0000_0000, 0);
      for (int i = 0; i < 12; i++) queue_step(0, 0);
      // random
      while (n_loads + n_steps < 540) begin
         if ($urandom_range(0, 9) == 0)
            queue_item(ReqLoad, 16'($urandom()), $urandom(), 0);
         else
            queue_step(0, n_steps == 300);
      end
      // halt, then steps and loads while halted
      core_regs[10] = core_regs[10];
      queue_item(ReqLoad, core_pc, HaltWord, 0);
      queue_step(1, 0);
      for (int i = 0; i < 8; i++) begin
         queue_step(1, 0);
         queue_item(ReqLoad, 16'($urandom()), $urandom(), 0);
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0 && n_done == n_sent && expected_results.size() == 0);
      repeat (20) @(posedge clock);
      if (expected_results.size() != 0) n_errors++;
      $display("tb: %0d load items and %0d step items, random idling and one long stall",
               n_loads, n_steps);
      if (n_errors == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== rv32i_instruction_step.f =====
hw/rtl/rv32i_pkg.sv
hw/rtl/rv32i_datapath.sv
hw/rtl/rv32i_ctrl.sv
hw/rtl/rv32i_instruction_step.sv
tb/tb.sv
